// ===== design/u8u16_pkg.sv =====
`default_nettype none
package u8u16_pkg;

  localparam logic [15:0] REPL_RESET = 16'h003F;
  localparam logic [15:0] SURR_HI    = 16'hD800;
  localparam logic [15:0] SURR_LO    = 16'hDC00;
  localparam logic [20:0] CP_SUPP    = 21'h010000;
  localparam logic [20:0] CP_MAX     = 21'h10FFFF;

  // Sequence lengths announced by a lead byte.
  localparam logic [2:0] LEN_NONE = 3'd0;
  localparam logic [2:0] LEN_TWO  = 3'd2;
  localparam logic [2:0] LEN_THREE = 3'd3;
  localparam logic [2:0] LEN_FOUR = 3'd4;

  localparam int CMD_DEPTH = 4;
  localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
  localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);

  typedef struct packed {
    logic [7:0] data_byte;
    logic       is_last;
  } in_word_t;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        run_last;
    logic        string_end;
  } out_word_t;

  // Work for the back end: rep_cnt replacements first, then up to two units.
  typedef struct packed {
    logic [2:0]  rep_cnt;
    logic [1:0]  last_idx;
    logic [15:0] unit0;
    logic [15:0] unit1;
    logic        is_last;
  } cmd_t;

endpackage
`default_nettype wire

// ===== design/utf8_to_utf16_transcoder_core.sv =====
`default_nettype none
// A pushed byte's command, if any, is written into the command queue; its first
// UTF-16 word is then registered at the output. One byte is accepted per cycle
// while the queue has room; the output drains one word per cycle when popped, so
// a byte yielding n words holds it until all n drain. A four-entry command queue
// between decoder and expander absorbs such bursts. Reset (rst, synchronous):
// no sequence open, queue and output emptied, replacement unit back to 003F.
module utf8_to_utf16_transcoder_core import u8u16_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire in_word_t    wr_data,
  output logic             empty,
  input  wire logic        pop,
  output out_word_t        rd_data,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] cfg_data
);

  logic [15:0] repl;
  logic        accept;
  logic        cmd_push;
  cmd_t        cmd;
  logic        cmd_pop;
  logic        cmd_valid;
  cmd_t        head;

  assign cfg_ready = 1'b1;
  assign accept = push && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      repl <= REPL_RESET;
    end else if (cfg_valid) begin
      repl <= cfg_data;
    end
  end

  u8u16_front u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .wr_data  (wr_data),
    .cmd_push (cmd_push),
    .cmd      (cmd)
  );

  u8u16_cmd_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (cmd_push),
    .wr_cmd    (cmd),
    .full      (full),
    .rd_en     (cmd_pop),
    .cmd_valid (cmd_valid),
    .head      (head)
  );

  u8u16_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .head      (head),
    .repl      (repl),
    .cmd_pop   (cmd_pop),
    .empty     (empty),
    .pop       (pop),
    .rd_data   (rd_data)
  );

endmodule
`default_nettype wire

// ===== design/u8u16_front.sv =====
`default_nettype none
module u8u16_front import u8u16_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     accept,
  input  wire in_word_t wr_data,
  output logic          cmd_push,
  output cmd_t          cmd
);

  logic [2:0]  exp_len;
  logic [1:0]  held;
  logic [20:0] partial;
  logic [2:0]  exp_len_next;
  logic [1:0]  held_next;
  logic [20:0] partial_next;

  logic [7:0]  b;
  logic        is_cont;
  logic [20:0] pc_cat;
  logic [19:0] v;
  logic [2:0]  rep;
  logic [1:0]  ucnt;
  logic [2:0]  total;
  logic [15:0] u0;
  logic [15:0] u1;

  always_comb begin
    b = wr_data.data_byte;
    is_cont = b inside {[8'h80:8'hBF]};
    pc_cat = {partial[14:0], b[5:0]};
    v = pc_cat[19:0] - CP_SUPP[19:0];
    exp_len_next = exp_len;
    held_next = held;
    partial_next = partial;
    rep = 3'd0;
    ucnt = 2'd0;
    u0 = 16'h0000;
    u1 = 16'h0000;
    if (exp_len != LEN_NONE && is_cont) begin
      if ({1'b0, held} + 3'd2 >= exp_len) begin
        if (pc_cat > CP_MAX) begin
          rep = 3'd1;
        end else if (pc_cat >= CP_SUPP) begin
          u0 = SURR_HI | {6'b0, v[19:10]};
          u1 = SURR_LO | {6'b0, v[9:0]};
          ucnt = 2'd2;
        end else begin
          u0 = pc_cat[15:0];
          ucnt = 2'd1;
        end
        exp_len_next = LEN_NONE;
        held_next = 2'd0;
        partial_next = 21'd0;
      end else if (wr_data.is_last) begin
        rep = {1'b0, held} + 3'd2;
        exp_len_next = LEN_NONE;
        held_next = 2'd0;
        partial_next = 21'd0;
      end else begin
        held_next = held + 2'd1;
        partial_next = pc_cat;
      end
    end else begin
      // A broken sequence flushes one replacement per buffered byte first.
      rep = (exp_len != LEN_NONE) ? {1'b0, held} + 3'd1 : 3'd0;
      exp_len_next = LEN_NONE;
      held_next = 2'd0;
      partial_next = 21'd0;
      if (!b[7]) begin
        u0 = {8'h00, b};
        ucnt = 2'd1;
      end else if (is_cont || b inside {[8'hF8:8'hFF]}) begin
        rep = rep + 3'd1;
      end else if (wr_data.is_last) begin
        rep = rep + 3'd1;
      end else begin
        if (b inside {[8'hC0:8'hDF]}) begin
          exp_len_next = LEN_TWO;
          partial_next = {16'd0, b[4:0]};
        end else if (b inside {[8'hE0:8'hEF]}) begin
          exp_len_next = LEN_THREE;
          partial_next = {17'd0, b[3:0]};
        end else begin
          exp_len_next = LEN_FOUR;
          partial_next = {18'd0, b[2:0]};
        end
      end
    end
    total = rep + {1'b0, ucnt};
    cmd_push = accept && (total != 3'd0);
    cmd.rep_cnt = rep;
    cmd.last_idx = 2'(total - 3'd1);
    cmd.unit0 = u0;
    cmd.unit1 = u1;
    cmd.is_last = wr_data.is_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      exp_len <= LEN_NONE;
      held <= 2'd0;
      partial <= 21'd0;
    end else if (accept) begin
      exp_len <= exp_len_next;
      held <= held_next;
      partial <= partial_next;
    end
  end

  // An open sequence never holds as many continuations as it needs.
  a_held_bound: assert property (@(posedge clk) disable iff (rst)
    exp_len != LEN_NONE |-> {1'b0, held} + 3'd2 <= exp_len)
    else $error("front holds too many continuation bytes");

endmodule
`default_nettype wire

// ===== design/u8u16_cmd_fifo.sv =====
`default_nettype none
module u8u16_cmd_fifo import u8u16_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic wr_en,
  input  wire cmd_t wr_cmd,
  output logic      full,
  input  wire logic rd_en,
  output logic      cmd_valid,
  output cmd_t      head
);

  cmd_t                 mem [CMD_DEPTH];
  logic [CMD_PTR_W-1:0] wr_ptr;
  logic [CMD_PTR_W-1:0] rd_ptr;
  logic [CMD_CNT_W-1:0] count;

  assign full = (count == CMD_CNT_W'(CMD_DEPTH));
  assign cmd_valid = (count != '0);
  assign head = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + CMD_PTR_W'(1);
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + CMD_PTR_W'(1);
      end
      if (wr_en && !rd_en) begin
        count <= count + CMD_CNT_W'(1);
      end else if (rd_en && !wr_en) begin
        count <= count - CMD_CNT_W'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> !full)
    else $error("command queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    rd_en |-> cmd_valid)
    else $error("command queue read while empty");

endmodule
`default_nettype wire

// ===== design/u8u16_back.sv =====
`default_nettype none
module u8u16_back import u8u16_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cmd_valid,
  input  wire cmd_t        head,
  input  wire logic [15:0] repl,
  output logic             cmd_pop,
  output logic             empty,
  input  wire logic        pop,
  output out_word_t        rd_data
);

  logic       out_valid;
  logic [1:0] idx;
  logic       load;
  logic       at_end;
  logic [2:0] tail_pos;
  out_word_t  unit;

  always_comb begin
    at_end = (idx == head.last_idx);
    tail_pos = {1'b0, idx} - head.rep_cnt;
    unit.run_last = at_end;
    unit.string_end = at_end && head.is_last;
    if ({1'b0, idx} < head.rep_cnt) begin
      unit.code_unit = repl;
    end else if (tail_pos[0]) begin
      unit.code_unit = head.unit1;
    end else begin
      unit.code_unit = head.unit0;
    end
    load = cmd_valid && (!out_valid || pop);
    cmd_pop = load && at_end;
  end

  assign empty = !out_valid;

  always_ff @(posedge clk) begin
    if (load) begin
      rd_data <= unit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx <= 2'd0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        idx <= at_end ? 2'd0 : idx + 2'd1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  // A command being expanded stays at the head of the queue until done.
  a_cmd_held: assert property (@(posedge clk) disable iff (rst)
    idx != 2'd0 |-> cmd_valid)
    else $error("command left the queue mid-expansion");

endmodule
`default_nettype wire
